// ----- sv/npss_pkg.sv -----
`default_nettype none
package npss_pkg;

  localparam int unsigned MaxPointsDef  = 64;
  localparam int unsigned MaxEntriesDef = 8;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] force_db;
  } key_t;

  typedef struct packed {
    logic        [15:0] sample;
    logic signed [15:0] tuning;
    logic        [15:0] volume;
  } entry_t;

  function automatic logic key_before(input key_t a, input key_t b);
    return (a.pitch < b.pitch) || ((a.pitch == b.pitch) && (a.force_db < b.force_db));
  endfunction

endpackage
`default_nettype wire

// ----- sv/npss_ram.sv -----
`default_nettype none
module npss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- sv/npss_cell.sv -----
`default_nettype none
module npss_cell
  import npss_pkg::*;
#(
  parameter int unsigned CntW = 4
) (
  input  wire logic            clk_i,
  input  wire logic            shift_i,
  input  wire key_t            key_i,
  input  wire logic [CntW-1:0] cnt_i,
  input  wire logic            load_i,
  input  wire key_t            load_key_i,
  input  wire logic [CntW-1:0] load_cnt_i,
  output key_t                 key_o,
  output logic      [CntW-1:0] cnt_o
);

  key_t            key_q;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q <= load_key_i;
      cnt_q <= load_cnt_i;
    end else if (shift_i) begin
      key_q <= key_i;
      cnt_q <= cnt_i;
    end
  end

  assign key_o = key_q;
  assign cnt_o = cnt_q;

endmodule
`default_nettype wire

// ----- sv/nearest_point_sample_selector.sv -----
`default_nettype none
// Map of up to MAX_POINTS (pitch, force) points, each with up to MAX_ENTRIES
// sample entries. The points sit in a ring of cells that rotates once per
// item past a single distance/compare unit, so every item (add or lookup)
// passes scan, flush, decide and emit (a lookup hit adds a read-wait state
// for the entry memory read); ring length sets scan length. One item is
// worked at a time; a finished result waits in the output register while
// the next beat is accepted. No clearing pass after reset.
module nearest_point_sample_selector
  import npss_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = MaxPointsDef,
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               func_i,
  input  wire logic signed [15:0] point_cents_i,
  input  wire logic signed [15:0] point_force_i,
  input  wire logic        [15:0] entry_sample_i,
  input  wire logic signed [15:0] entry_tuning_i,
  input  wire logic        [15:0] entry_volume_i,
  input  wire logic        [15:0] random_draw_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    ok_o,
  output logic             [15:0] found_sample_o,
  output logic signed      [15:0] found_tuning_o,
  output logic             [15:0] found_volume_o,
  output logic signed      [15:0] found_point_cents_o
);

  localparam int unsigned PtW   = $clog2(MAX_POINTS);
  localparam int unsigned PiuW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned Depth = MAX_POINTS * MAX_ENTRIES;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [AddrW-1:0] MeA     = AddrW'(MAX_ENTRIES);
  localparam logic [PtW-1:0]   LastPt  = PtW'(MAX_POINTS - 1);
  localparam logic [PiuW-1:0]  FullPiu = PiuW'(MAX_POINTS);
  localparam logic [CntW-1:0]  MaxCnt  = CntW'(MAX_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FLUSH, S_DECIDE, S_RDWAIT, S_EMIT
  } state_e;

  state_e          state_q;
  logic [PtW-1:0]  step_q;
  logic [PiuW-1:0] piu_q;

  logic            func_q;
  key_t            qkey_q;
  entry_t          qent_q;
  logic [15:0]     draw_q;

  key_t            ring_key [MAX_POINTS];
  logic [CntW-1:0] ring_cnt [MAX_POINTS];
  logic [MAX_POINTS-1:0] load_vec;
  key_t            ld_key;
  logic [CntW-1:0] ld_cnt;
  logic            shift;

  logic            a_v_q, a_low_q, a_eq_q;
  logic [PtW-1:0]  a_idx_q;
  logic [CntW-1:0] a_cnt_q;
  key_t            a_key_q;
  logic [31:0]     a_sqc_q, a_sqf_q;

  logic            have_q, best_low_q;
  logic [42:0]     best_d_q;
  logic [PtW-1:0]  best_idx_q;
  logic [CntW-1:0] best_cnt_q;
  key_t            best_key_q;

  logic            m_found_q;
  logic [PtW-1:0]  m_idx_q;
  logic [CntW-1:0] m_cnt_q;

  logic            res_ok_q;
  entry_t          res_ent_q;
  logic [15:0]     res_pc_q;

  logic            we;
  logic [AddrW-1:0] waddr, raddr;
  entry_t          rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign shift      = (state_q == S_SCAN);

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    npss_cell #(.CntW(CntW)) u_cell (
      .clk_i      (clk_i),
      .shift_i    (shift),
      .key_i      (ring_key[(k + 1) % MAX_POINTS]),
      .cnt_i      (ring_cnt[(k + 1) % MAX_POINTS]),
      .load_i     (load_vec[k]),
      .load_key_i (ld_key),
      .load_cnt_i (ld_cnt),
      .key_o      (ring_key[k]),
      .cnt_o      (ring_cnt[k])
    );
  end

  npss_ram #(.Width($bits(entry_t)), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (qent_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // head cell distance
  logic signed [16:0] dc, df;
  logic [15:0]        ac, af;
  logic               h_low, h_eq;
  assign dc    = {ring_key[0].pitch[15], ring_key[0].pitch} - {qkey_q.pitch[15], qkey_q.pitch};
  assign df    = {ring_key[0].force_db[15], ring_key[0].force_db}
               - {qkey_q.force_db[15], qkey_q.force_db};
  assign ac    = dc[16] ? 16'(-dc) : dc[15:0];
  assign af    = df[16] ? 16'(-df) : df[15:0];
  assign h_eq  = (ring_key[0] == qkey_q);
  assign h_low = h_eq || key_before(ring_key[0], qkey_q);

  logic [42:0] cand_d;
  logic        take;
  assign cand_d = {1'b0, a_sqc_q, 10'b0} + 43'(a_sqf_q);
  always_comb begin
    if (!have_q || cand_d < best_d_q) begin
      take = 1'b1;
    end else if (cand_d > best_d_q) begin
      take = 1'b0;
    end else if (a_low_q != best_low_q) begin
      take = a_low_q;
    end else if (a_low_q) begin
      take = key_before(best_key_q, a_key_q);
    end else begin
      take = key_before(a_key_q, best_key_q);
    end
  end

  function automatic logic [15+CntW:0] random_draw_mul(input logic [15:0] d,
                                                       input logic [CntW-1:0] c);
    return (16 + CntW)'(d) * (16 + CntW)'(c);
  endfunction

  logic [15+CntW:0] prod;
  logic             add_match_ok, add_new_ok;
  assign prod         = random_draw_mul(draw_q, best_cnt_q);
  assign add_match_ok = m_found_q && (m_cnt_q < MaxCnt);
  assign add_new_ok   = !m_found_q && (piu_q != FullPiu);
  assign raddr        = AddrW'(best_idx_q) * MeA + AddrW'(prod[15+CntW:16]);

  always_comb begin
    load_vec = '0;
    ld_key   = qkey_q;
    ld_cnt   = '0;
    we       = 1'b0;
    waddr    = '0;
    if (state_q == S_DECIDE && func_q == FUNC_ADD) begin
      if (add_match_ok) begin
        we                = 1'b1;
        waddr             = AddrW'(m_idx_q) * MeA + AddrW'(m_cnt_q);
        load_vec[m_idx_q] = 1'b1;
        ld_cnt            = m_cnt_q + 1'b1;
      end else if (add_new_ok) begin
        we                          = 1'b1;
        waddr                       = AddrW'(piu_q[PtW-1:0]) * MeA;
        load_vec[piu_q[PtW-1:0]]    = 1'b1;
        ld_cnt                      = CntW'(1);
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk_i) begin
    a_idx_q <= step_q;
    a_cnt_q <= ring_cnt[0];
    a_key_q <= ring_key[0];
    a_sqc_q <= 32'(ac) * 32'(ac);
    a_sqf_q <= 32'(af) * 32'(af);
    a_low_q <= h_low;
    a_eq_q  <= h_eq;
    if (a_v_q && take) begin
      best_d_q   <= cand_d;
      best_low_q <= a_low_q;
      best_idx_q <= a_idx_q;
      best_cnt_q <= a_cnt_q;
      best_key_q <= a_key_q;
    end
    if (a_v_q && a_eq_q) begin
      m_idx_q <= a_idx_q;
      m_cnt_q <= a_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      piu_q       <= '0;
      a_v_q       <= 1'b0;
      have_q      <= 1'b0;
      m_found_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      a_v_q <= (state_q == S_SCAN) && (PiuW'(step_q) < piu_q);
      if (a_v_q && take) begin
        have_q <= 1'b1;
      end
      if (a_v_q && a_eq_q) begin
        m_found_q <= 1'b1;
      end
      if (out_valid_o && !out_stall_i && state_q != S_EMIT) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q    <= func_i;
            qkey_q    <= '{pitch: point_cents_i, force_db: point_force_i};
            qent_q    <= '{sample: entry_sample_i, tuning: entry_tuning_i,
                           volume: entry_volume_i};
            draw_q    <= random_draw_i;
            step_q    <= '0;
            have_q    <= 1'b0;
            m_found_q <= 1'b0;
            state_q   <= S_SCAN;
          end
        end
        S_SCAN: begin
          step_q <= step_q + 1'b1;
          if (step_q == LastPt) begin
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          res_ent_q <= '0;
          res_pc_q  <= '0;
          if (func_q == FUNC_ADD) begin
            res_ok_q <= add_match_ok || add_new_ok;
            if (add_new_ok) begin
              piu_q <= piu_q + 1'b1;
            end
            state_q <= S_EMIT;
          end else if (!have_q) begin
            res_ok_q <= 1'b0;
            state_q  <= S_EMIT;
          end else begin
            state_q <= S_RDWAIT;
          end
        end
        S_RDWAIT: begin
          res_ok_q  <= 1'b1;
          res_ent_q <= rdata;
          res_pc_q  <= best_key_q.pitch;
          state_q   <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o         <= 1'b1;
            ok_o                <= res_ok_q;
            found_sample_o      <= res_ent_q.sample;
            found_tuning_o      <= res_ent_q.tuning;
            found_volume_o      <= res_ent_q.volume;
            found_point_cents_o <= res_pc_q;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
